// ----- hdl/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg
// types and constants shared by the seam cumulative energy block
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

  // field widths
  localparam int ENERGY_W  = 8;
  localparam int SUM_W     = 18;
  localparam int CFG_LEN_W = 13;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH     = 1'b0,
    CFG_SCAN_BY_COLUMNS = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_LEN_W-1:0] LINE_LENGTH_RST = CFG_LEN_W'(640);

  // input beat
  typedef struct packed {
    logic [ENERGY_W-1:0] pixel_energy;
    logic                frame_start;
  } in_t;

  // result beat
  typedef struct packed {
    logic [SUM_W-1:0] cumulative_energy;
    logic             line_end;
  } out_t;

endpackage

`default_nettype wire

// ----- hdl/sce_line_store.sv -----
// ----------------------------------------------------------------------------
// sce_line_store
// previous-line store: one write and one registered read per cycle, with
// write-to-read bypass when both hit the same entry in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sce_line_store
  import sce_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [SUM_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [SUM_W-1:0]  rd_data
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      // bypass: the entry is being written at this very edge
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/seam_cumulative_energy.sv -----
// ----------------------------------------------------------------------------
// seam_cumulative_energy
// pipeline: stage-1 register, then result register; out_ready stalls both
// throughput: one beat per cycle unless stalled; single line-store read+write
// reset: synchronous active-low; clears pipeline valids, position and the
// first-line flag; the line store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module seam_cumulative_energy
  import sce_pkg::*;
#(
  parameter int MAX_LINE_LENGTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_LINE_LENGTH);
  // wide enough to hold both the register and MAX_LINE_LENGTH itself
  localparam int CMP_W  = (((ADDR_W + 1) > CFG_LEN_W) ? (ADDR_W + 1) : CFG_LEN_W) + 1;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [CFG_LEN_W-1:0] line_length_r;

  // the orientation bit only tells upstream how the image is walked; the
  // arithmetic is the same either way, so nothing here holds it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LINE_LENGTH_RST;
    end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_LINE_LENGTH)) begin
      line_length_r <= cfg_wdata[CFG_LEN_W-1:0];
    end
  end

  // effective length minus one: length clamped to 2..MAX_LINE_LENGTH, so 1..MAX-1
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  max_ext;
  logic [CMP_W-1:0]  last_pos_w;
  logic [ADDR_W-1:0] last_pos;

  always_comb begin
    len_ext = CMP_W'(line_length_r);
    max_ext = CMP_W'(MAX_LINE_LENGTH);
    if (len_ext >= max_ext) begin
      last_pos_w = max_ext - CMP_W'(1);
    end else if (len_ext < CMP_W'(2)) begin
      last_pos_w = CMP_W'(1);
    end else begin
      last_pos_w = len_ext - CMP_W'(1);
    end
    last_pos = last_pos_w[ADDR_W-1:0];
  end

  // --------------------------------------------------------------------------
  // handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  // stage 1 moves on when the result register is free or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // stage 0: position tracking and line-store read issue
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] pos_r;
  logic              first_r;

  logic [ADDR_W-1:0] pos_in;
  logic              first_in;
  logic              last_in;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    // a frame start restarts at line zero before the beat is handled
    pos_in   = in_data.frame_start ? '0 : pos_r;
    first_in = in_data.frame_start | first_r;
    last_in  = (pos_in >= last_pos);
    // right-hand neighbour on the previous line; only used when not last
    rd_addr  = pos_in + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= 1'b1;
    end else if (in_acc) begin
      if (last_in) begin
        pos_r   <= '0;
        first_r <= 1'b0;
      end else begin
        pos_r   <= pos_in + ADDR_W'(1);
        first_r <= first_in;
      end
    end
  end

  // stage 1 input register
  logic [ENERGY_W-1:0] s1_energy_r;
  logic [ADDR_W-1:0]   s1_pos_r;
  logic                s1_last_r;
  logic                s1_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_energy_r <= in_data.pixel_energy;
      s1_pos_r    <= pos_in;
      s1_last_r   <= last_in;
      s1_first_r  <= first_in;
    end
  end

  // --------------------------------------------------------------------------
  // line store
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] result;
  logic [SUM_W-1:0] right_rd;

  sce_line_store #(
    .DEPTH  (MAX_LINE_LENGTH),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_pos_r),
    .wr_data (result),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (right_rd)
  );

  // --------------------------------------------------------------------------
  // stage 1: neighbour selection, min of three, saturating add
  // --------------------------------------------------------------------------
  // copy of entry zero, so the line start never needs a second read port
  logic [SUM_W-1:0] entry0_r;
  logic [SUM_W-1:0] left_r;
  logic [SUM_W-1:0] centre_r;

  logic [SUM_W-1:0] centre;
  logic [SUM_W-1:0] left;
  logic [SUM_W-1:0] right;
  logic [SUM_W-1:0] min_lc;
  logic [SUM_W-1:0] min3;
  logic [SUM_W:0]   sum;
  logic             line_start;

  always_comb begin
    line_start = (s1_pos_r == '0);
    centre     = line_start ? entry0_r : centre_r;
    // at either edge the missing neighbour falls back to the centre
    left       = line_start ? centre : left_r;
    right      = s1_last_r ? centre : right_rd;
    min_lc     = (left < centre) ? left : centre;
    min3       = (min_lc < right) ? min_lc : right;
    sum        = {1'b0, min3} + (SUM_W + 1)'(s1_energy_r);
    if (s1_first_r) begin
      result = SUM_W'(s1_energy_r);
    end else if (sum[SUM_W]) begin
      result = '1;
    end else begin
      result = sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && line_start) begin
      entry0_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      centre_r <= '0;
    end else if (s1_adv && !s1_first_r) begin
      left_r   <= centre;
      centre_r <= right;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.cumulative_energy <= result;
      out_data_r.line_end          <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the last beat of a line wraps the position and leaves the first line
  a_line_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_in) |=> (pos_r == '0) && !first_r)
    else $error("position did not wrap after line end");

  // a first-line beat passes its energy straight through
  a_first_pass : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_first_r) |=>
      (out_data_r.cumulative_energy == SUM_W'($past(s1_energy_r))))
    else $error("first-line result differs from pixel energy");

  // line end flag follows the stage-1 beat into the result register
  a_line_end : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && (out_data_r.line_end == $past(s1_last_r)))
    else $error("result register not loaded on stage advance");

  // a frame start always marks its beat as first-line in stage 1
  a_frame_start : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.frame_start) |=> s1_valid_r && s1_first_r && (s1_pos_r == '0))
    else $error("frame start did not restart the line");

endmodule

`default_nettype wire
